### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ALT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with the consequent checked in the next cycle.
`define ALT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/alt_pkg.sv
package alt_pkg;

  typedef struct packed {
    logic [63:0] hw_high;
    logic [63:0] hw_low;
    logic [31:0] ip;
    logic [31:0] expiry;
  } entry_t;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_FIND_HW = 2'd1;
  localparam logic [1:0] CMD_FIND_IP = 2'd2;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_ENTRIES = 3'd0;
  localparam logic [6:0] ENTRIES_RESET = 7'd64;

endpackage

### rtl/alt_cell.sv
// One table entry; takes its neighbor's entry on every shift.
module alt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  alt_pkg::entry_t d_i,
  output alt_pkg::entry_t q_o
);

  alt_pkg::entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

### rtl/address_lease_table.sv
// Address lease table. The entries sit in a ring of cells that rotates by one
// entry per cycle while a command runs; all matching, clearing and writing
// happens at the head cell. A find takes one full rotation, an add takes two
// (clear and oldest-expiry search, then write); an unused command goes
// straight to the result. A finished result waits until the previous one has
// left the output register. Configure entries_in_use at address 0 only while
// idle. Reset clears the whole table at once.
`include "assert_macros.svh"

module address_lease_table #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [63:0]                  hw_addr_high_i,
  input  logic [63:0]                  hw_addr_low_i,
  input  logic [31:0]                  ip_addr_i,
  input  logic [31:0]                  lease_seconds_i,
  input  logic [31:0]                  now_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [5:0]                   slot_o,
  output logic [63:0]                  out_hw_high_o,
  output logic [63:0]                  out_hw_low_o,
  output logic [31:0]                  out_ip_o,
  output logic [31:0]                  out_expiry_o,
  output logic                         expired_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned N_W   = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_WR, S_FIND, S_DONE} state_e;

  state_e          state_q;
  logic [6:0]      entries_q;
  logic [IDX_W-1:0] cnt_q;
  logic [1:0]      cmd_q;
  alt_pkg::entry_t req_q;
  logic [31:0]     now_q;
  logic [31:0]     oldest_q;
  logic [IDX_W-1:0] pick_q;
  logic            have_q;
  logic            hit_q;
  logic [IDX_W-1:0] cap_slot_q;
  alt_pkg::entry_t cap_q;
  logic            cap_exp_q;
  logic            out_valid_q;
  logic            out_found_q;
  logic [5:0]      out_slot_q;
  alt_pkg::entry_t out_q;
  logic            out_exp_q;

  alt_pkg::entry_t cell_q [MAX_ENTRIES];
  alt_pkg::entry_t cell_d [MAX_ENTRIES];
  alt_pkg::entry_t head, head_new;
  logic            shift;
  logic [N_W-1:0]  n_act;
  logic            in_range, hw_nz, hw_eq, ip_eq, clr_match;
  logic [31:0]     eff_exp;
  logic            last;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {25'd0, entries_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= alt_pkg::ENTRIES_RESET;
    end else if (psel && penable && pwrite && paddr == alt_pkg::ADDR_ENTRIES) begin
      entries_q <= pwdata[6:0];
    end
  end

  assign n_act = (32'(entries_q) > MAX_ENTRIES) ? N_W'(MAX_ENTRIES) : N_W'(entries_q);

  // Ring of cells
  assign shift = (state_q == S_CLR) || (state_q == S_WR) || (state_q == S_FIND);
  assign head  = cell_q[0];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign cell_d[k] = head_new;
    end else begin : g_mid
      assign cell_d[k] = cell_q[k+1];
    end
    alt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .d_i    (cell_d[k]),
      .q_o    (cell_q[k])
    );
  end

  assign in_range  = ({1'b0, cnt_q} < (IDX_W+1)'(n_act));
  assign hw_nz     = (req_q.hw_high != '0) || (req_q.hw_low != '0);
  assign hw_eq     = (head.hw_high == req_q.hw_high) && (head.hw_low == req_q.hw_low);
  assign ip_eq     = (head.ip == req_q.ip);
  assign clr_match = (hw_nz && hw_eq) || ((req_q.ip != '0) && ip_eq);
  assign eff_exp   = clr_match ? 32'd0 : head.expiry;
  assign last      = (cnt_q == LAST_IDX);

  always_comb begin
    head_new = head;
    if (state_q == S_CLR && in_range && clr_match) begin
      head_new = '0;
    end else if (state_q == S_WR && have_q && cnt_q == pick_q) begin
      head_new = req_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      req_q       <= '0;
      now_q       <= '0;
      oldest_q    <= '0;
      pick_q      <= '0;
      cap_slot_q  <= '0;
      cap_q       <= '0;
      cap_exp_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_slot_q  <= '0;
      out_q       <= '0;
      out_exp_q   <= 1'b0;
    end else begin
      // a result loaded in S_DONE takes precedence over the drop
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (shift) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q         <= cmd_i;
            req_q.hw_high <= hw_addr_high_i;
            req_q.hw_low  <= hw_addr_low_i;
            req_q.ip      <= ip_addr_i;
            req_q.expiry  <= now_i + lease_seconds_i;
            now_q         <= now_i;
            oldest_q      <= now_i;
            have_q        <= 1'b0;
            hit_q         <= 1'b0;
            pick_q        <= '0;
            cap_slot_q    <= '0;
            cap_q         <= '0;
            cap_exp_q     <= 1'b0;
            case (cmd_i)
              alt_pkg::CMD_ADD:     state_q <= S_CLR;
              alt_pkg::CMD_FIND_HW: state_q <= S_FIND;
              alt_pkg::CMD_FIND_IP: state_q <= S_FIND;
              default:              state_q <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          if (in_range && eff_exp < oldest_q) begin
            oldest_q <= eff_exp;
            pick_q   <= cnt_q;
            have_q   <= 1'b1;
          end
          if (last) begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          if (have_q && cnt_q == pick_q) begin
            hit_q      <= 1'b1;
            cap_slot_q <= cnt_q;
            cap_q      <= req_q;
            cap_exp_q  <= (req_q.expiry < now_q);
          end
          if (last) begin
            state_q <= S_DONE;
          end
        end
        S_FIND: begin
          if (in_range && !hit_q &&
              ((cmd_q == alt_pkg::CMD_FIND_HW) ? hw_eq : ip_eq)) begin
            hit_q      <= 1'b1;
            cap_slot_q <= cnt_q;
            cap_q      <= head;
            cap_exp_q  <= (head.expiry < now_q);
          end
          if (last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_found_q <= hit_q;
            out_slot_q  <= 6'(cap_slot_q);
            out_q       <= cap_q;
            out_exp_q   <= cap_exp_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign slot_o        = out_slot_q;
  assign out_hw_high_o = out_q.hw_high;
  assign out_hw_low_o  = out_q.hw_low;
  assign out_ip_o      = out_q.ip;
  assign out_expiry_o  = out_q.expiry;
  assign expired_o     = out_exp_q;

  `ALT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `ALT_ASSERT_IMP(a_cnt_idle_zero, state_q == S_IDLE || state_q == S_DONE, cnt_q == '0)
  `ALT_ASSERT_IMP(a_miss_zero, out_valid_q && !out_found_q, out_slot_q == '0 && out_q == '0)

endmodule
